### hdl/vefi_pkg.sv
// shared types, widths and helpers for the edge flux / volume fraction pipeline
// no dependencies; used by every module of the block
package vefi_pkg;

    localparam int VALUE_WIDTH = 24;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int PROD_W      = 2 * VALUE_WIDTH + 1;
    localparam int NUM_W       = 2 * VALUE_WIDTH + 2;
    localparam int QUO_W       = FRAC_BITS + 2;

    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic signed [PROD_W-1:0] SAT_MAX =
        {{(VALUE_WIDTH + 2){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef enum logic [2:0] {
        REG_EMPTY   = 3'd0,
        REG_FULL    = 3'd1,
        REG_LOW     = 3'd2,
        REG_HIGH    = 3'd3,
        REG_LINEAR  = 3'd4,
        REG_NO_FLUX = 3'd5
    } region_t;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic   no_flux;
        value_t nx;
        value_t ny;
        value_t d;
    } geom_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
        region_t          region;
    } div_in_t;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        region_t          region;
    } div_out_t;

    function automatic value_t sat_value(input logic signed [PROD_W-1:0] x);
        value_t r;
        if (x > SAT_MAX) begin
            r = SAT_MAX[VALUE_WIDTH-1:0];
        end else if (x < SAT_MIN) begin
            r = SAT_MIN[VALUE_WIDTH-1:0];
        end else begin
            r = x[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/vof_edge_flux_from_interface_core.sv
// an accepted input beat reaches its result beat through 2 front end stages,
// 2 decode stages, 18 divider stages and the result register
// throughput: one beat per cycle; every stage takes a new beat each cycle it can move
// each stage holds its beat only while the stage after it is full and stalled
// reset: aresetn synchronous active low, clears every stage valid; no clearing pass
// top level of the edge flux / cut-cell fraction pipeline
// depends on vefi_pkg, vefi_prep, vefi_classify, vefi_div
module vof_edge_flux_from_interface_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic signed [vefi_pkg::VALUE_WIDTH-1:0] s_normal_x,
    input  logic signed [vefi_pkg::VALUE_WIDTH-1:0] s_normal_y,
    input  logic signed [vefi_pkg::VALUE_WIDTH-1:0] s_offset,
    input  logic signed [1:0]                   s_dir_x,
    input  logic signed [1:0]                   s_dir_y,
    input  logic signed [vefi_pkg::VALUE_WIDTH-1:0] s_flux_x,
    input  logic signed [vefi_pkg::VALUE_WIDTH-1:0] s_flux_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [vefi_pkg::FRAC_W-1:0]         m_fraction,
    output logic [2:0]                          m_region
);

    localparam int FW = vefi_pkg::FRAC_W;
    localparam int QW = vefi_pkg::QUO_W;

    // front end: flux dot products, shifted interface for edge beats
    logic               prep_valid, prep_ready;
    vefi_pkg::geom_t    prep_geom;

    // region decode and squared numerators
    logic               cls_valid, cls_ready;
    vefi_pkg::div_in_t  cls_div;

    // divider output
    logic               div_valid, div_ready;
    vefi_pkg::div_out_t div_res;

    // output register
    logic               m_valid_reg;
    logic [FW-1:0]      m_fraction_reg, fraction_next;
    vefi_pkg::region_t  m_region_reg;
    logic [QW-1:0]      quo_q, quo_h;

    vefi_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .kind      (s_kind),
        .nx        (s_normal_x),
        .ny        (s_normal_y),
        .d         (s_offset),
        .dir_x     (s_dir_x),
        .dir_y     (s_dir_y),
        .flux_x    (s_flux_x),
        .flux_y    (s_flux_y),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_geom  (prep_geom)
    );

    vefi_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_geom   (prep_geom),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_div   (cls_div)
    );

    vefi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_div    (cls_div),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_div   (div_res)
    );

    // quotient carries two spare bits: corners want floor(x*2^(F-2)),
    // the linear band floor(x*2^(F-1))
    assign quo_q = div_res.quo >> 2;
    assign quo_h = div_res.quo >> 1;

    always_comb begin
        unique case (div_res.region) inside
            vefi_pkg::REG_EMPTY, vefi_pkg::REG_NO_FLUX: begin
                fraction_next = '0;
            end
            vefi_pkg::REG_FULL: begin
                fraction_next = vefi_pkg::FRAC_ONE;
            end
            vefi_pkg::REG_LOW: begin
                fraction_next = FW'(quo_q);
            end
            vefi_pkg::REG_HIGH: begin
                fraction_next = vefi_pkg::FRAC_ONE - FW'(quo_q);
            end
            vefi_pkg::REG_LINEAR: begin
                // clamp to a full cell at the top of the band
                if (quo_h > QW'(vefi_pkg::FRAC_ONE)) begin
                    fraction_next = vefi_pkg::FRAC_ONE;
                end else begin
                    fraction_next = FW'(quo_h);
                end
            end
            default: begin
                fraction_next = '0;
            end
        endcase
    end

    // result register parts the divider from the consumer
    assign div_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_ready) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ready && div_valid) begin
            m_fraction_reg <= fraction_next;
            m_region_reg   <= div_res.region;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_fraction = m_fraction_reg;
    assign m_region   = m_region_reg;

    // a full cell always reports exactly one
    a_full_is_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_region_reg == vefi_pkg::REG_FULL)
            |-> (m_fraction_reg == vefi_pkg::FRAC_ONE))
        else $error("full region with fraction other than one");

    // empty cell and blocked flux both give zero
    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_region_reg == vefi_pkg::REG_EMPTY ||
                         m_region_reg == vefi_pkg::REG_NO_FLUX))
            |-> (m_fraction_reg == '0))
        else $error("empty or no-flux region with nonzero fraction");

    // fraction never above one
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_fraction_reg <= vefi_pkg::FRAC_ONE))
        else $error("fraction above one");

    // nothing leaves the pipe in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid_reg)
        else $error("result beat straight after reset");

endmodule

### hdl/vefi_prep.sv
// two-stage front end: flux products, then shifted normal and offset
// depends on vefi_pkg
module vefi_prep (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  vefi_pkg::value_t           nx,
    input  vefi_pkg::value_t           ny,
    input  vefi_pkg::value_t           d,
    input  logic signed [1:0]          dir_x,
    input  logic signed [1:0]          dir_y,
    input  vefi_pkg::value_t           flux_x,
    input  vefi_pkg::value_t           flux_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output vefi_pkg::geom_t            out_geom
);

    localparam int V  = vefi_pkg::VALUE_WIDTH;
    localparam int PW = 2 * V;
    localparam int SW = V + 3;
    localparam int DW = V + 4;
    localparam int XW = vefi_pkg::PROD_W;

    logic adv1, adv2;

    // stage 1 registers
    logic                  v1_reg;
    logic                  kind1_reg;
    vefi_pkg::value_t      nx1_reg, ny1_reg, d1_reg;
    logic signed [PW-1:0]  px1_reg, py1_reg;
    logic signed [SW-1:0]  q1_reg;
    logic                  flow1_reg;
    logic                  dxnz1_reg, dynz1_reg;

    logic signed [PW-1:0]  px_next, py_next;
    logic signed [SW-1:0]  s_next, q_next;

    // stage 2 registers
    logic                  v2_reg;
    vefi_pkg::geom_t       geom2_reg;

    logic signed [XW-1:0]  psum, pshift;
    vefi_pkg::value_t      p_val, id_val;
    logic signed [DW-1:0]  diff, half, idsum;
    vefi_pkg::geom_t       geom_next;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign px_next = PW'(nx) * PW'(flux_x);
    assign py_next = PW'(ny) * PW'(flux_y);
    assign s_next  = SW'(dir_x) * SW'(flux_x) + SW'(dir_y) * SW'(flux_y);
    assign q_next  = SW'(dir_x) * SW'(nx) + SW'(dir_y) * SW'(ny);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            kind1_reg <= kind;
            nx1_reg   <= nx;
            ny1_reg   <= ny;
            d1_reg    <= d;
            px1_reg   <= px_next;
            py1_reg   <= py_next;
            q1_reg    <= q_next;
            flow1_reg <= s_next > 0;
            dxnz1_reg <= dir_x != 2'sd0;
            dynz1_reg <= dir_y != 2'sd0;
        end
    end

    // projected flux, then half of its excess over the edge normal component
    assign psum   = XW'(px1_reg) + XW'(py1_reg);
    assign pshift = psum >>> vefi_pkg::FRAC_BITS;
    assign p_val  = vefi_pkg::sat_value(pshift);
    assign diff   = DW'(p_val) - DW'(q1_reg);
    assign half   = diff >>> 1;
    assign idsum  = DW'(d1_reg) + half;
    assign id_val = vefi_pkg::sat_value(XW'(idsum));

    always_comb begin
        geom_next.no_flux = kind1_reg && !flow1_reg;
        geom_next.nx      = (kind1_reg && dxnz1_reg) ? p_val : nx1_reg;
        geom_next.ny      = (kind1_reg && dynz1_reg) ? p_val : ny1_reg;
        geom_next.d       = kind1_reg ? id_val : d1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            geom2_reg <= geom_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_geom  = geom2_reg;

endmodule

### hdl/vefi_classify.sv
// two-stage region decode and numerator / denominator products
// depends on vefi_pkg
module vefi_classify (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vefi_pkg::geom_t     in_geom,
    output logic                out_valid,
    input  logic                out_ready,
    output vefi_pkg::div_in_t   out_div
);

    localparam int V  = vefi_pkg::VALUE_WIDTH;
    localparam int CW = V + 3;
    localparam int NW = vefi_pkg::NUM_W;

    logic adv1, adv2;

    logic [V-1:0]          ax, ay, mx, mn;
    logic [V:0]            n;
    logic signed [CW-1:0]  d2, ns, mns, mxs, low_bound, high_bound;
    logic signed [CW-1:0]  a_low, a_high, lin;
    vefi_pkg::region_t     region_next;
    logic [V:0]            a_next;

    logic                  v1_reg;
    vefi_pkg::region_t     region1_reg;
    logic [V:0]            a1_reg, lin1_reg;
    logic [V-1:0]          mn1_reg, mx1_reg;

    logic [NW-1:0]         asq;
    logic [2*V-1:0]        mnmx;
    vefi_pkg::div_in_t     div_next;

    logic                  v2_reg;
    vefi_pkg::div_in_t     div2_reg;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign ax = in_geom.nx[V-1] ? (~in_geom.nx + 1'b1) : in_geom.nx;
    assign ay = in_geom.ny[V-1] ? (~in_geom.ny + 1'b1) : in_geom.ny;
    assign n  = {1'b0, ax} + {1'b0, ay};
    assign mx = (ax > ay) ? ax : ay;
    assign mn = V'(n - {1'b0, mx});

    assign d2         = CW'(in_geom.d) + CW'(in_geom.d);
    assign ns         = $signed(CW'(n));
    assign mns        = $signed(CW'(mn));
    assign mxs        = $signed(CW'(mx));
    assign low_bound  = mns + mns - ns;
    assign high_bound = ns - mns - mns;
    assign a_low      = d2 + ns;
    assign a_high     = ns - d2;
    assign lin        = d2 + mxs;

    always_comb begin
        a_next = a_low[V:0];
        if (in_geom.no_flux) begin
            region_next = vefi_pkg::REG_NO_FLUX;
        end else if (d2 <= -ns) begin
            region_next = vefi_pkg::REG_EMPTY;
        end else if (d2 >= ns) begin
            region_next = vefi_pkg::REG_FULL;
        end else if (d2 < low_bound) begin
            region_next = vefi_pkg::REG_LOW;
        end else if (d2 > high_bound) begin
            region_next = vefi_pkg::REG_HIGH;
            a_next      = a_high[V:0];
        end else begin
            region_next = vefi_pkg::REG_LINEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            region1_reg <= region_next;
            a1_reg      <= a_next;
            lin1_reg    <= lin[V:0];
            mn1_reg     <= mn;
            mx1_reg     <= mx;
        end
    end

    assign asq  = a1_reg * a1_reg;
    assign mnmx = mn1_reg * mx1_reg;

    always_comb begin
        div_next.region = region1_reg;
        if (region1_reg == vefi_pkg::REG_LINEAR) begin
            div_next.num = NW'(lin1_reg);
            div_next.den = NW'(mx1_reg);
        end else begin
            div_next.num = asq;
            div_next.den = NW'({mnmx, 1'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            div2_reg <= div_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_div   = div2_reg;

endmodule

### hdl/vefi_div.sv
// pipelined restoring divider, one quotient bit per stage: floor(num * 2^F / den)
// depends on vefi_pkg; num is known to stay below four times den
module vefi_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vefi_pkg::div_in_t   in_div,
    output logic                out_valid,
    input  logic                out_ready,
    output vefi_pkg::div_out_t  out_div
);

    localparam int NW = vefi_pkg::NUM_W;
    localparam int QW = vefi_pkg::QUO_W;

    logic                 v_reg   [QW];
    logic [NW-1:0]        rem_reg [QW];
    logic [NW-1:0]        den_reg [QW];
    logic [QW-1:0]        quo_reg [QW];
    vefi_pkg::region_t    rgn_reg [QW];
    logic [QW:0]          adv;

    assign adv[QW] = out_ready;

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [NW-1:0]     r_in, d_in, r_sh, d_cmp, r_diff;
        logic [QW-1:0]     q_in;
        vefi_pkg::region_t g_in;
        logic              v_in;
        logic              ge;

        if (j == 0) begin : g_first
            assign r_in = in_div.num;
            assign d_in = in_div.den;
            assign q_in = '0;
            assign g_in = in_div.region;
            assign v_in = in_valid;
        end else begin : g_next
            assign r_in = rem_reg[j-1];
            assign d_in = den_reg[j-1];
            assign q_in = quo_reg[j-1];
            assign g_in = rgn_reg[j-1];
            assign v_in = v_reg[j-1];
        end

        // first step weighs 2x den, second 1x, then one fraction bit each
        assign r_sh   = (j >= 2) ? {r_in[NW-2:0], 1'b0} : r_in;
        assign d_cmp  = (j == 0) ? {d_in[NW-2:0], 1'b0} : d_in;
        assign ge     = r_sh >= d_cmp;
        assign r_diff = r_sh - d_cmp;
        assign adv[j] = !v_reg[j] || adv[j+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (adv[j]) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[j] && v_in) begin
                rem_reg[j] <= ge ? r_diff : r_sh;
                den_reg[j] <= d_in;
                quo_reg[j] <= {q_in[QW-2:0], ge};
                rgn_reg[j] <= g_in;
            end
        end
    end

    assign in_ready       = adv[0];
    assign out_valid      = v_reg[QW-1];
    assign out_div.quo    = quo_reg[QW-1];
    assign out_div.region = rgn_reg[QW-1];

endmodule

### tb/vof_edge_flux_from_interface_core_tb.sv
// testbench for the edge flux / cut-cell fraction pipeline: random and directed beats,
// with its own fixed-point fraction predictor and an in-order scoreboard
// depends on vefi_pkg and vof_edge_flux_from_interface_core
`timescale 1ns / 1ps

module vof_edge_flux_from_interface_core_tb;

    localparam int VW = vefi_pkg::VALUE_WIDTH;
    localparam int FB = vefi_pkg::FRAC_BITS;
    localparam int FW = vefi_pkg::FRAC_W;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_kind;
    logic signed [VW-1:0] s_normal_x;
    logic signed [VW-1:0] s_normal_y;
    logic signed [VW-1:0] s_offset;
    logic signed [1:0]    s_dir_x;
    logic signed [1:0]    s_dir_y;
    logic signed [VW-1:0] s_flux_x;
    logic signed [VW-1:0] s_flux_y;
    logic                 m_valid;
    logic                 m_ready;
    logic [FW-1:0]        m_fraction;
    logic [2:0]           m_region;

    typedef struct packed {
        logic [FW-1:0]     fraction;
        vefi_pkg::region_t region;
    } cut_result_t;

    cut_result_t expected_cuts[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    vof_edge_flux_from_interface_core u_top (.*);

    // clock, period 8 ns
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // generous fixed limit on the whole run
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // floor(num * 2^bits / den) by restoring long division
    function automatic longint unsigned frac_quotient(longint unsigned num,
                                                      longint unsigned den, int bits);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < bits; i++) begin
            if (r >= den - r) begin
                r = r - (den - r);
                q = (q << 1) | 1;
            end else begin
                r = r << 1;
                q = q << 1;
            end
        end
        return q;
    endfunction

    function automatic longint clamp_value(longint v);
        longint hi;
        hi = (longint'(1) <<< (VW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // floor division by 2^s for signed values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic cut_result_t cut_fraction(longint nx, longint ny, longint d);
        cut_result_t     r;
        longint          ax;
        longint          ay;
        longint          n;
        longint          mx;
        longint          mn;
        longint          d2;
        longint unsigned den;
        longint unsigned a;
        longint unsigned f;
        ax = nx < 0 ? -nx : nx;
        ay = ny < 0 ? -ny : ny;
        n  = ax + ay;
        mx = ax > ay ? ax : ay;
        mn = n - mx;
        d2 = 2 * d;
        den = 2 * longint'(mn) * longint'(mx);
        if (d2 <= -n) begin
            r.fraction = '0;
            r.region   = vefi_pkg::REG_EMPTY;
        end else if (d2 >= n) begin
            r.fraction = vefi_pkg::FRAC_ONE;
            r.region   = vefi_pkg::REG_FULL;
        end else if (d2 < 2 * mn - n) begin
            a = d2 + n;
            r.fraction = FW'(frac_quotient(a * a, den, FB - 2));
            r.region   = vefi_pkg::REG_LOW;
        end else if (d2 > n - 2 * mn) begin
            a = n - d2;
            r.fraction = FW'((longint'(1) << FB) - frac_quotient(a * a, den, FB - 2));
            r.region   = vefi_pkg::REG_HIGH;
        end else begin
            f = (longint'(d2 + mx) << (FB - 1)) / mx;
            if (f > (longint'(1) << FB)) f = longint'(1) << FB;
            r.fraction = FW'(f);
            r.region   = vefi_pkg::REG_LINEAR;
        end
        return r;
    endfunction

    function automatic cut_result_t predict_cut(logic kind, longint nx, longint ny,
                                                longint d, longint dx, longint dy,
                                                longint fx, longint fy);
        cut_result_t r;
        longint      p;
        longint      q;
        if (!kind) return cut_fraction(nx, ny, d);
        if (dx * fx + dy * fy <= 0) begin
            r.fraction = '0;
            r.region   = vefi_pkg::REG_NO_FLUX;
            return r;
        end
        p = clamp_value(floor_shift(nx * fx + ny * fy, FB));
        q = dx * nx + dy * ny;
        return cut_fraction(dx == 0 ? nx : p, dy == 0 ? ny : p,
                            clamp_value(d + floor_shift(p - q, 1)));
    endfunction

    // drive one beat and wait for it to be taken; valid drops only in idle cycles
    task automatic send_beat(logic kind, logic signed [VW-1:0] nx, logic signed [VW-1:0] ny,
                             logic signed [VW-1:0] d, logic signed [1:0] dx,
                             logic signed [1:0] dy, logic signed [VW-1:0] fx,
                             logic signed [VW-1:0] fy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_normal_x <= nx;
        s_normal_y <= ny;
        s_offset   <= d;
        s_dir_x    <= dx;
        s_dir_y    <= dy;
        s_flux_x   <= fx;
        s_flux_y   <= fy;
        expected_cuts.push_back(predict_cut(kind, nx, ny, d, dx, dy, fx, fy));
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // value with a random magnitude class so small cells and extremes both appear
    function automatic logic signed [VW-1:0] rand_value();
        case ($urandom_range(3))
            0: return VW'($urandom);
            1: return VW'(int'($urandom_range(262143)) - 131072);
            2: return VW'(int'($urandom_range(4095)) - 2048);
            default: return VW'(int'($urandom_range(131072)) - 65536);
        endcase
    endfunction

    task automatic send_random_beat();
        logic signed [VW-1:0] nx;
        logic signed [VW-1:0] ny;
        nx = rand_value();
        ny = rand_value();
        send_beat($urandom_range(1), nx, ny,
                  // offsets mostly within the band so corners and linear part show up
                  $urandom_range(3) == 0 ? rand_value()
                                         : VW'(int'($urandom_range(131072)) - 65536),
                  2'($urandom), 2'($urandom), rand_value(), rand_value());
    endtask

    task automatic test_directed();
        logic signed [VW-1:0] vmax;
        logic signed [VW-1:0] vmin;
        vmax = {1'b0, {(VW - 1){1'b1}}};
        vmin = {1'b1, {(VW - 1){1'b0}}};
        // empty, full and zero normal
        send_beat(0, 65536, 0, -40000, 0, 0, 0, 0);
        send_beat(0, 65536, 0, 40000, 0, 0, 0, 0);
        send_beat(0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(0, 0, 0, 1, 0, 0, 0, 0);
        // low corner, high corner, linear
        send_beat(0, 65536, 32768, -40000, 0, 0, 0, 0);
        send_beat(0, 65536, 32768, 40000, 0, 0, 0, 0);
        send_beat(0, 65536, 16384, 1000, 0, 0, 0, 0);
        send_beat(0, -65536, -65536, 0, 0, 0, 0, 0);
        // field extremes
        send_beat(0, vmax, vmin, vmax, 2'b01, 2'b10, vmax, vmin);
        send_beat(0, vmin, vmin, vmin, 2'b11, 2'b11, vmin, vmin);
        send_beat(0, vmax, vmax, 0, 0, 0, vmax, vmax);
        // edge flux: no inward flux, inward, saturation, direction pattern 10
        send_beat(1, 65536, 0, 0, 1, 0, -65536, 0);
        send_beat(1, 65536, 0, 0, 1, 0, 0, 0);
        send_beat(1, 65536, 32768, 1000, 1, 0, 20000, 5000);
        send_beat(1, 30000, -50000, -2000, 0, -1, 3000, -40000);
        send_beat(1, vmax, vmax, vmax, 1, 1, vmax, vmax);
        send_beat(1, vmin, vmax, vmin, 2'b10, 2'b10, vmin, vmin);
        send_beat(1, 40000, 20000, 0, 2'b10, 0, -30000, 7000);
        send_beat(1, vmax, vmin, 0, 1, -1, vmax, vmin);
    endtask

    task automatic test_random(int count);
        repeat (count) send_random_beat();
    endtask

    // receiver: random stalls, in-order comparison on each accepted result beat
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cut_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cuts.size() == 0) begin
                $error("unexpected result beat: fraction %0d region %0d",
                       m_fraction, m_region);
                fail_count++;
            end else begin
                want = expected_cuts.pop_front();
                if (m_fraction !== want.fraction) begin
                    $error("fraction: expected %0d actual %0d", want.fraction, m_fraction);
                    fail_count++;
                end
                if (m_region !== want.region) begin
                    $error("region: expected %0d actual %0d", want.region, m_region);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count    = 0;
        send_idle_pct = 24;
        recv_idle_pct = 65;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = 1'b0;
        s_normal_x = '0;
        s_normal_y = '0;
        s_offset   = '0;
        s_dir_x    = '0;
        s_dir_y    = '0;
        s_flux_x   = '0;
        s_flux_y   = '0;
        m_ready    = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(350);
        send_idle_pct = 65;
        recv_idle_pct = 24;
        test_random(340);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(340);
        s_valid <= 1'b0;

        while (expected_cuts.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0 && expected_cuts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
